FILE: rtl/clpsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clpsr_pkg;

    // Duty fixed-point format
    localparam int DUTY_FRAC_BITS = 16;
    localparam int DUTY_W         = 23;
    localparam int LIM_W          = 15;
    localparam int SPEED_W        = 16;

    // Rounding shifts
    localparam int P_SHIFT   = 32 - DUTY_FRAC_BITS;
    localparam int AW_SHIFT  = 16;
    localparam int DRV_SHIFT = DUTY_FRAC_BITS;

    // Divider: magnitude of error times headroom fits 31 bits
    localparam int DIV_W     = 31;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int QUOT_W    = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [DUTY_W-1:0] RST_DUTY_ZERO = DUTY_W'(64'd50 << DUTY_FRAC_BITS);
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX  = DUTY_W'(64'd100 << DUTY_FRAC_BITS);
    localparam logic [DUTY_W-1:0] RST_DUTY_MIN  = '0;
    localparam logic [LIM_W-1:0]  RST_CUR_LIMIT = 15'd5000;
    localparam logic [31:0]       RST_P_GAIN    = 32'd21475;
    localparam logic [15:0]       RST_AW_GAIN   = 16'd39322;
    localparam logic [15:0]       RST_PERIOD    = 16'd10;
    localparam logic [31:0]       RST_DRV_SCALE = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_ZERO   = 3'd0,
        REG_DUTY_MAX    = 3'd1,
        REG_DUTY_MIN    = 3'd2,
        REG_CUR_LIMIT   = 3'd3,
        REG_P_GAIN      = 3'd4,
        REG_AW_GAIN     = 3'd5,
        REG_PERIOD      = 3'd6,
        REG_DRV_SCALE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_zero;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_min;
        logic [LIM_W-1:0]  current_limit;
        logic [31:0]       proportional_gain;
        logic [15:0]       anti_windup_gain;
        logic [15:0]       update_period;
        logic [31:0]       drive_scale;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic drv_mul;
        logic out_load;
        logic cut_load;
        logic chk;
        logic div_start;
        logic pin;
        logic p_mul;
        logic aw_mul;
        logic sum;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic cd_last;
        logic out_free;
        logic cut;
        logic div_done;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/clpsr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface clpsr_tick_if;
    import clpsr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SPEED_W-1:0]  target_speed;
    logic signed [SPEED_W-1:0]  measured_speed;
    logic signed [SPEED_W-1:0]  motor_current;

    modport source (output valid, target_speed, measured_speed, motor_current, input ready);
    modport sink   (input valid, target_speed, measured_speed, motor_current, output ready);
endinterface

interface clpsr_res_if;
    import clpsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [DUTY_W-1:0]  applied_duty;
    logic signed [31:0] drive_value;

    modport source (output valid, applied_duty, drive_value, input ready);
    modport sink   (input valid, applied_duty, drive_value, output ready);
endinterface

interface clpsr_cfg_if;
    import clpsr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/current_limited_pi_speed_regulator.sv
// Current-limited PI speed regulator.
// i_tick carries one word per control tick: target speed, measured speed and
// motor current. A countdown reloaded from update_period picks every N-th tick;
// on that tick one word leaves on o_res with the duty applied during the
// period just ended and its signed drive value, and the next duty is computed.
// i_cfg writes the eight registers by index; write it only while idle.
// The drive product is registered in ST_DRV, then ST_OUT loads the result word
// into the output register. A tick that causes no result keeps i_tick.ready
// high. An update tick holds it low through the 31-step current derating divider
// (to ST_CHK when the current exceeds the limit and the duty drops to neutral).
// A result waits in an output register; when the receiver stalls, the block
// holds before loading the next result, and otherwise runs on.
// Reset (synchronous, active low) restores register defaults, reloads the
// countdown with 10 and sets the stored duty to the neutral point.
`timescale 1ns / 1ps
`default_nettype none

module current_limited_pi_speed_regulator (
    input  wire          i_clk,
    input  wire          i_rst_n,
    clpsr_tick_if.sink   i_tick,
    clpsr_res_if.source  o_res,
    clpsr_cfg_if.sink    i_cfg
);
    import clpsr_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_sts  sts;
    logic  in_ready;

    assign i_tick.ready = in_ready;

    clpsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    clpsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    clpsr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_target_speed   (i_tick.target_speed),
        .i_measured_speed (i_tick.measured_speed),
        .i_motor_current  (i_tick.motor_current),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_applied_duty   (o_res.applied_duty),
        .o_drive_value    (o_res.drive_value)
    );

endmodule

`default_nettype wire

FILE: rtl/clpsr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module clpsr_cfg (
    input  wire              i_clk,
    input  wire              i_rst_n,
    clpsr_cfg_if.sink        i_cfg,
    output clpsr_pkg::t_cfg  o_cfg
);
    import clpsr_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_zero         <= RST_DUTY_ZERO;
            r_cfg.duty_max          <= RST_DUTY_MAX;
            r_cfg.duty_min          <= RST_DUTY_MIN;
            r_cfg.current_limit     <= RST_CUR_LIMIT;
            r_cfg.proportional_gain <= RST_P_GAIN;
            r_cfg.anti_windup_gain  <= RST_AW_GAIN;
            r_cfg.update_period     <= RST_PERIOD;
            r_cfg.drive_scale       <= RST_DRV_SCALE;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_DUTY_ZERO: r_cfg.duty_zero         <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MAX:  r_cfg.duty_max          <= i_cfg.data[DUTY_W-1:0];
                REG_DUTY_MIN:  r_cfg.duty_min          <= i_cfg.data[DUTY_W-1:0];
                REG_CUR_LIMIT: r_cfg.current_limit     <= i_cfg.data[LIM_W-1:0];
                REG_P_GAIN:    r_cfg.proportional_gain <= i_cfg.data[31:0];
                REG_AW_GAIN:   r_cfg.anti_windup_gain  <= i_cfg.data[15:0];
                REG_PERIOD:    r_cfg.update_period     <= i_cfg.data[15:0];
                REG_DRV_SCALE: r_cfg.drive_scale       <= i_cfg.data[31:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/clpsr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module clpsr_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire [clpsr_pkg::DIV_W-1:0]   i_dividend,
    input  wire [clpsr_pkg::LIM_W-1:0]   i_divisor,
    output logic [clpsr_pkg::DIV_W-1:0]  o_quotient,
    output logic                         o_done
);
    import clpsr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quot;
    logic [LIM_W-1:0]     r_rem;
    logic [LIM_W-1:0]     r_dvs;

    logic [LIM_W:0]       rem_sh;
    logic                 ge;
    logic [LIM_W:0]       rem_sub;

    // One quotient bit per cycle, dividend shifts out as quotient shifts in
    assign rem_sh  = {r_rem, r_quot[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    assign o_quotient = r_quot;
    assign o_done     = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], ge};
            r_rem  <= ge ? rem_sub[LIM_W-1:0] : rem_sh[LIM_W-1:0];
        end
    end

    // Derated error never exceeds the raw error range
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_done) && r_dvs != '0) |-> (r_quot[DIV_W-1:QUOT_W] == '0))
        else $error("divider quotient out of range");

endmodule

`default_nettype wire

FILE: rtl/clpsr_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module clpsr_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  clpsr_pkg::t_cfg                     i_cfg,
    input  clpsr_pkg::t_cmd                     i_cmd,
    output clpsr_pkg::t_sts                     o_sts,
    input  wire signed [clpsr_pkg::SPEED_W-1:0] i_target_speed,
    input  wire signed [clpsr_pkg::SPEED_W-1:0] i_measured_speed,
    input  wire signed [clpsr_pkg::SPEED_W-1:0] i_motor_current,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [clpsr_pkg::DUTY_W-1:0]        o_applied_duty,
    output logic signed [31:0]                  o_drive_value
);
    import clpsr_pkg::*;

    localparam logic signed [48:0] P_HALF   = 49'sd1 <<< (P_SHIFT - 1);
    localparam logic signed [49:0] AW_HALF  = 50'sd1 <<< (AW_SHIFT - 1);
    localparam logic signed [56:0] DRV_HALF = 57'sd1 <<< (DRV_SHIFT - 1);

    // Control state
    logic [15:0]              r_countdown;
    logic [15:0]              n_countdown;
    logic [DUTY_W-1:0]        r_stored;
    logic signed [23:0]       r_acc;
    logic signed [31:0]       r_unc;
    logic                     r_out_valid;
    logic                     n_out_valid;

    // Payload
    logic signed [SPEED_W-1:0] r_tgt;
    logic signed [SPEED_W-1:0] r_meas;
    logic signed [SPEED_W-1:0] r_cur;
    logic signed [56:0]        r_prod_d;
    logic signed [32:0]        r_num;
    logic signed [32:0]        r_d;
    logic signed [15:0]        r_pin;
    logic signed [48:0]        r_pprod;
    logic signed [48:0]        r_p;
    logic signed [49:0]        r_awprod;
    logic [DUTY_W-1:0]         r_out_duty;
    logic signed [31:0]        r_out_drv;

    logic [16:0]               cur_mag;
    logic                      cut;
    logic [LIM_W-1:0]          headroom;
    logic signed [16:0]        err;
    logic signed [32:0]        num_prod;
    logic [32:0]               num_abs;
    logic signed [32:0]        u_ext;
    logic signed [32:0]        max_ext;
    logic signed [32:0]        min_ext;
    logic signed [32:0]        d_val;
    logic [DIV_W-1:0]          quot;
    logic                      div_done;
    logic signed [15:0]        pin_val;
    logic signed [48:0]        pprod;
    logic signed [48:0]        p_biased;
    logic signed [49:0]        awprod;
    logic signed [49:0]        aw_biased;
    logic signed [49:0]        aw_val;
    logic signed [51:0]        sum_val;
    logic signed [23:0]        diff;
    logic signed [56:0]        prod_d;
    logic signed [56:0]        drv_biased;
    logic signed [56:0]        drv_shift;
    logic signed [31:0]        unc_max;
    logic signed [31:0]        unc_min;
    logic [DUTY_W-1:0]         duty_next;

    // Current check and derating numerator
    assign cur_mag  = r_cur[SPEED_W-1] ? (17'd0 - {r_cur[SPEED_W-1], r_cur}) : {1'b0, r_cur};
    assign cut      = cur_mag > {2'b00, i_cfg.current_limit};
    assign headroom = i_cfg.current_limit - cur_mag[LIM_W-1:0];
    assign err      = {r_tgt[SPEED_W-1], r_tgt} - {r_meas[SPEED_W-1], r_meas};
    assign num_prod = err * $signed({1'b0, headroom});
    assign num_abs  = r_num[32] ? (33'd0 - r_num) : r_num;

    // Anti-windup excess of the previous unclamped output
    assign u_ext   = {r_unc[31], r_unc};
    assign max_ext = $signed({10'd0, i_cfg.duty_max});
    assign min_ext = $signed({10'd0, i_cfg.duty_min});

    always_comb begin
        if (u_ext > max_ext) begin
            d_val = u_ext - max_ext;
        end else if (u_ext < min_ext) begin
            d_val = u_ext - min_ext;
        end else begin
            d_val = '0;
        end
    end

    clpsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (num_abs[DIV_W-1:0]),
        .i_divisor  (i_cfg.current_limit),
        .o_quotient (quot),
        .o_done     (div_done)
    );

    // Sign and saturate the quotient
    always_comb begin
        if (i_cfg.current_limit == '0) begin
            pin_val = '0;
        end else if (!r_num[32]) begin
            pin_val = (quot > DIV_W'(32767)) ? 16'sh7FFF : $signed(quot[15:0]);
        end else begin
            pin_val = (quot > DIV_W'(32768)) ? 16'sh8000 : $signed(16'd0 - quot[15:0]);
        end
    end

    // Round half away from zero: bias by half, one less when negative
    assign pprod     = r_pin * $signed({1'b0, i_cfg.proportional_gain});
    assign p_biased  = r_pprod + (r_pprod[48] ? (P_HALF - 49'sd1) : P_HALF);
    assign awprod    = r_d * $signed({1'b0, i_cfg.anti_windup_gain});
    assign aw_biased = r_awprod + (r_awprod[49] ? (AW_HALF - 50'sd1) : AW_HALF);
    assign aw_val    = aw_biased >>> AW_SHIFT;

    assign sum_val = 52'(r_acc) + 52'(r_p) - 52'(aw_val) + {29'd0, i_cfg.duty_zero};

    // Output clamp, max test first
    assign unc_max = $signed({9'd0, i_cfg.duty_max});
    assign unc_min = $signed({9'd0, i_cfg.duty_min});

    always_comb begin
        if (r_unc > unc_max) begin
            duty_next = i_cfg.duty_max;
        end else if (r_unc < unc_min) begin
            duty_next = i_cfg.duty_min;
        end else begin
            duty_next = r_unc[DUTY_W-1:0];
        end
    end

    // Drive value
    assign diff       = $signed({1'b0, r_stored}) - $signed({1'b0, i_cfg.duty_zero});
    assign prod_d     = diff * $signed({1'b0, i_cfg.drive_scale});
    assign drv_biased = r_prod_d + (r_prod_d[56] ? (DRV_HALF - 57'sd1) : DRV_HALF);
    assign drv_shift  = drv_biased >>> DRV_SHIFT;

    assign o_sts.cd_last  = r_countdown == 16'd1;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.cut      = cut;
    assign o_sts.div_done = div_done;

    assign n_countdown = (r_countdown == 16'd1) ? i_cfg.update_period : r_countdown - 16'd1;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_countdown <= RST_PERIOD;
            r_stored    <= RST_DUTY_ZERO;
            r_acc       <= '0;
            r_unc       <= $signed({9'd0, RST_DUTY_ZERO});
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.tick) begin
                r_countdown <= n_countdown;
            end
            if (i_cmd.cut_load) begin
                r_stored <= i_cfg.duty_zero;
            end
            if (i_cmd.sum) begin
                r_unc <= sat32(64'(sum_val));
            end
            if (i_cmd.commit) begin
                r_stored <= duty_next;
                r_acc    <= $signed({1'b0, duty_next}) - $signed({1'b0, i_cfg.duty_zero});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_tgt  <= i_target_speed;
            r_meas <= i_measured_speed;
            r_cur  <= i_motor_current;
        end
        if (i_cmd.drv_mul) begin
            r_prod_d <= prod_d;
        end
        if (i_cmd.out_load) begin
            r_out_duty <= r_stored;
            r_out_drv  <= sat32(64'(drv_shift));
        end
        if (i_cmd.chk) begin
            r_num <= num_prod;
            r_d   <= d_val;
        end
        if (i_cmd.pin) begin
            r_pin <= pin_val;
        end
        if (i_cmd.p_mul) begin
            r_pprod <= pprod;
        end
        if (i_cmd.aw_mul) begin
            r_awprod <= awprod;
            r_p      <= p_biased >>> P_SHIFT;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_applied_duty = r_out_duty;
    assign o_drive_value  = r_out_drv;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten while pending");

    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick && o_sts.cd_last) |=> (r_countdown == $past(i_cfg.update_period)))
        else $error("countdown not reloaded on expiry");

    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> ((r_stored == i_cfg.duty_max) || (r_stored == i_cfg.duty_min) ||
                          (r_stored >= i_cfg.duty_min && r_stored <= i_cfg.duty_max)))
        else $error("stored duty outside clamp range");

endmodule

`default_nettype wire

FILE: rtl/clpsr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module clpsr_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  clpsr_pkg::t_sts  i_sts,
    output clpsr_pkg::t_cmd  o_cmd
);
    import clpsr_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_DRV    = 11'b000_0000_0010,
        ST_OUT    = 11'b000_0000_0100,
        ST_CHK    = 11'b000_0000_1000,
        ST_DSTART = 11'b000_0001_0000,
        ST_DIV    = 11'b000_0010_0000,
        ST_PIN    = 11'b000_0100_0000,
        ST_PMUL   = 11'b000_1000_0000,
        ST_AWMUL  = 11'b001_0000_0000,
        ST_SUM    = 11'b010_0000_0000,
        ST_CLAMP  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = r_state == ST_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.tick = 1'b1;
                    if (i_sts.cd_last) begin
                        n_state = ST_DRV;
                    end
                end
            end
            ST_DRV: begin
                o_cmd.drv_mul = 1'b1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.cut) begin
                    o_cmd.cut_load = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.chk = 1'b1;
                    n_state   = ST_DSTART;
                end
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_PIN;
                end
            end
            ST_PIN: begin
                o_cmd.pin = 1'b1;
                n_state   = ST_PMUL;
            end
            ST_PMUL: begin
                o_cmd.p_mul = 1'b1;
                n_state     = ST_AWMUL;
            end
            ST_AWMUL: begin
                o_cmd.aw_mul = 1'b1;
                n_state      = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
